// ===== rtl/core/dq_pkg.sv =====
// Shared types and constants of the double-ended queue.
package dq_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_fetch;
   } stat_type;

endpackage

// ===== rtl/core/dq_ctrl.sv =====
// Sequencer of the double-ended queue: load, execute, refresh, respond.
module dq_ctrl import dq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.need_fetch ? S_FETCH : S_RESP;
         end
         S_FETCH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         S_FETCH: begin
            busy      = 1'b1;
            cmd.fetch = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/dq_datapath.sv =====
// Ring buffer store, pointers and cached end words of the double-ended queue.
module dq_datapath import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [2:0]               req_operation,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic                     rsp_popped_valid,
   output logic [1:0]               rsp_status,
   output logic [CW-1:0]            rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_back_value
);

   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
      return (i == LAST) ? '0 : AW'(i + 1'b1);
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
      return (i == '0) ? LAST : AW'(i - 1'b1);
   endfunction

   // (h + n) mod DEPTH, both below DEPTH
   function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] h,
                                             input logic [AW-1:0] n);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, n};
      if (s >= DEPTH_W) s = s - DEPTH_W;
      return s[AW-1:0];
   endfunction

   logic [WORD_W-1:0] mem [DEPTH];

   op_type            op_ff;
   logic [WORD_W-1:0] value_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [WORD_W-1:0] front_ff, front_in;
   logic [WORD_W-1:0] back_ff, back_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic              pvalid_ff, pvalid_in;
   status_type        status_ff, status_in;
   logic              fetch_front_ff, fetch_front_in;
   logic [WORD_W-1:0] rd_data_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              need_fetch;
   logic              is_full, is_empty;
   logic [CW-1:0]     count_m2;

   assign is_full  = (count_ff == FULL_C);
   assign is_empty = (count_ff == '0);
   assign count_m2 = count_ff - CW'(2);

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      popped_in      = '0;
      pvalid_in      = 1'b0;
      status_in      = ST_OK;
      fetch_front_in = 1'b1;
      wr_en          = 1'b0;
      wr_addr        = idx_dec(head_ff);
      rd_addr        = idx_inc(head_ff);
      need_fetch     = 1'b0;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               head_in  = idx_dec(head_ff);
               count_in = count_ff + 1'b1;
               front_in = value_ff;
               if (is_empty) back_in = value_ff;
            end
         end
         OP_PUSH_BACK: begin
            wr_addr = idx_add(head_ff, count_ff[AW-1:0]);
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               back_in  = value_ff;
               if (is_empty) front_in = value_ff;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in  = front_ff;
               pvalid_in  = 1'b1;
               head_in    = idx_inc(head_ff);
               count_in   = count_ff - 1'b1;
               need_fetch = (count_ff != CW'(1));
            end
         end
         OP_POP_BACK: begin
            // new back sits at head + count - 2
            rd_addr        = idx_add(head_ff, count_m2[AW-1:0]);
            fetch_front_in = 1'b0;
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in  = back_ff;
               pvalid_in  = 1'b1;
               count_in   = count_ff - 1'b1;
               need_fetch = (count_ff != CW'(1));
            end
         end
         default: begin
            if (is_empty) status_in = ST_EMPTY;
         end
      endcase
   end

   assign stat.need_fetch = need_fetch;

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_push_value;
      end
      if (cmd.exec) begin
         front_ff       <= front_in;
         back_ff        <= back_in;
         popped_ff      <= popped_in;
         pvalid_ff      <= pvalid_in;
         status_ff      <= status_in;
         fetch_front_ff <= fetch_front_in;
      end else if (cmd.fetch) begin
         if (fetch_front_ff) begin
            front_ff <= rd_data_ff;
         end else begin
            back_ff <= rd_data_ff;
         end
      end
   end

   assign rsp_popped_value = popped_ff;
   assign rsp_popped_valid = pvalid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_is_empty     = is_empty;
   assign rsp_front_value  = is_empty ? '0 : front_ff;
   assign rsp_back_value   = is_empty ? '0 : back_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("word count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST)
      else $error("head index out of range");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_empty && (op_ff == OP_POP_FRONT || op_ff == OP_POP_BACK))
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not remove one word");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_full && (op_ff == OP_PUSH_FRONT || op_ff == OP_PUSH_BACK))
      |=> $stable(count_ff) && $stable(head_ff))
      else $error("push into full queue changed state");
`endif

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
// A word is taken when start is high and busy is low. Its result appears
// on the rsp_ ports for exactly one cycle, with rsp_valid high, and cannot be
// held off. A push, a peek, a spare code, or a pop that empties the queue or
// finds it empty goes from the execute state straight to the response state;
// a pop that leaves words behind passes through a fetch state first, as the
// new end word is read back through the single registered read port of the
// word store. start is taken again in the result cycle. Front and back words
// are cached in registers; no clearing pass is needed after reset.
module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_operation,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic                     rsp_popped_valid,
   output logic [1:0]               rsp_status,
   output logic [CW-1:0]            rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic signed [WORD_W-1:0] rsp_front_value,
   output logic signed [WORD_W-1:0] rsp_back_value
);

   cmd_type  cmd;
   stat_type stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the double_ended_queue block.
`timescale 1ns / 1ps

module tb_top;
   import dq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [2:0] OP_SPARE_MIN = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_MAX = 3'd7;
   localparam int GAP_MAX = 8;
   localparam int EXP_SLOTS = 16;
   localparam int DIR_MAX = 32;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped;
      logic                     pop_ok;
      logic [1:0]               status;
      logic [CW-1:0]            count;
      logic                     empty;
      logic signed [WORD_W-1:0] front;
      logic signed [WORD_W-1:0] back;
   } outcome_type;

   typedef struct {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] val;
      bit                       typed;
      outcome_type              exp;
   } stim_row_type;

   localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
   localparam outcome_type NOTHING_STORED =
      '{32'sd0, 1'b0, ST_EMPTY, '0, 1'b1, 32'sd0, 32'sd0};

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [2:0]               req_operation;
   logic signed [WORD_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_popped_value;
   logic                     rsp_popped_valid;
   logic [1:0]               rsp_status;
   logic [CW-1:0]            rsp_entry_count;
   logic                     rsp_is_empty;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_back_value;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value)
   );

   // shadow deque
   logic signed [WORD_W-1:0] word_mem [DEPTH];
   logic [$clog2(DEPTH)-1:0] head_ptr;
   logic [CW-1:0]            fill_count;

   // expected words in flight, written by the driver, read by the checker
   outcome_type  exp_mem [EXP_SLOTS];
   int           exp_wr = 0;
   int           exp_rd = 0;
   stim_row_type dir_rows [DIR_MAX];
   int           dir_n = 0;
   int           mismatches = 0;
   bit           gaps_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("double_ended_queue: mismatch");
      $finish;
   end

   function automatic outcome_type dq_apply(input logic [2:0] op,
                                            input logic signed [WORD_W-1:0] val);
      outcome_type              o;
      logic [$clog2(DEPTH)-1:0] slot;
      o = '0;
      o.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_count >= DEPTH) begin
               o.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               head_ptr = head_ptr - 1'b1;
               word_mem[head_ptr] = val;
               fill_count++;
            end else begin
               slot = head_ptr + fill_count[$clog2(DEPTH)-1:0];
               word_mem[slot] = val;
               fill_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (fill_count == 0) begin
               o.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
               o.popped = word_mem[head_ptr];
               o.pop_ok = 1'b1;
               head_ptr = head_ptr + 1'b1;
               fill_count--;
            end else begin
               slot = head_ptr + fill_count[$clog2(DEPTH)-1:0] - 1'b1;
               o.popped = word_mem[slot];
               o.pop_ok = 1'b1;
               fill_count--;
            end
         end
         default: begin
            // peek and the spare codes
            if (fill_count == 0) o.status = ST_EMPTY;
         end
      endcase
      o.count = fill_count;
      o.empty = (fill_count == 0);
      if (fill_count != 0) begin
         slot = head_ptr + fill_count[$clog2(DEPTH)-1:0] - 1'b1;
         o.front = word_mem[head_ptr];
         o.back = word_mem[slot];
      end
      return o;
   endfunction

   function automatic void add_row(input logic [2:0] op,
                                   input logic signed [WORD_W-1:0] val,
                                   input bit typed, input outcome_type want);
      dir_rows[dir_n] = '{op, val, typed, want};
      dir_n++;
   endfunction

   function automatic logic [2:0] pick_op(input int push_pct, input int pop_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      if (r < push_pct + pop_pct + 3) return 3'($urandom_range(OP_SPARE_MIN, OP_SPARE_MAX));
      return OP_PEEK;
   endfunction

   function automatic logic signed [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 19))
         0:       return W_MAX;
         1:       return W_MIN;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $signed($urandom);
      endcase
   endfunction

   // busy is sampled at the rising edge; the word is taken when it is low
   task automatic send_word(input logic [2:0] op, input logic signed [WORD_W-1:0] val,
                            input bit typed, input outcome_type typed_exp);
      int          gap;
      outcome_type pred;
      if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
      gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_push_value = val;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = dq_apply(op, val);
      exp_mem[exp_wr % EXP_SLOTS] = typed ? typed_exp : pred;
      exp_wr++;
      @(negedge clock);
   endtask

   task automatic send_random(input int push_pct, input int pop_pct);
      send_word(pick_op(push_pct, pop_pct), rand_word(), 1'b0, '0);
   endtask

   task automatic drain_outcomes();
      start = 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_popped_value, rsp_popped_valid, rsp_status, rsp_entry_count,
                 rsp_is_empty, rsp_front_value, rsp_back_value};
         if (exp_wr == exp_rd) begin
            if (mismatches < 10) $display("unexpected word: cnt %0d", got.count);
            mismatches++;
         end else begin
            want = exp_mem[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (got.popped !== want.popped || got.pop_ok !== want.pop_ok ||
                got.status !== want.status || got.count !== want.count ||
                got.empty !== want.empty || got.front !== want.front ||
                got.back !== want.back) begin
               if (mismatches < 10) begin
                  $display("exp pop %0d/%0b st %0d cnt %0d emp %0b f %0d b %0d",
                           want.popped, want.pop_ok, want.status, want.count,
                           want.empty, want.front, want.back);
                  $display("got pop %0d/%0b st %0d cnt %0d emp %0b f %0d b %0d",
                           got.popped, got.pop_ok, got.status, got.count,
                           got.empty, got.front, got.back);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_PEEK;
      req_push_value = '0;
      head_ptr = '0;
      fill_count = '0;
      gaps_on = 1'b1;

      // empty deque, extremes, head wrap below slot zero, spare codes
      add_row(OP_POP_FRONT, 32'sd0, 1'b1, NOTHING_STORED);
      add_row(OP_POP_BACK, 32'sd0, 1'b1, NOTHING_STORED);
      add_row(OP_PEEK, 32'sd0, 1'b1, NOTHING_STORED);
      add_row(OP_SPARE_MIN, 32'sd9, 1'b1, NOTHING_STORED);
      add_row(OP_SPARE_MID, 32'sd0, 1'b1, NOTHING_STORED);
      add_row(OP_SPARE_MAX, W_MAX, 1'b1, NOTHING_STORED);
      add_row(OP_PUSH_BACK, W_MAX, 1'b1,
              '{32'sd0, 1'b0, ST_OK, CW'(1), 1'b0, W_MAX, W_MAX});
      add_row(OP_PUSH_FRONT, W_MIN, 1'b1,
              '{32'sd0, 1'b0, ST_OK, CW'(2), 1'b0, W_MIN, W_MAX});
      add_row(OP_PEEK, 32'sd5, 1'b1,
              '{32'sd0, 1'b0, ST_OK, CW'(2), 1'b0, W_MIN, W_MAX});
      add_row(OP_PUSH_FRONT, -32'sd1, 1'b0, '0);
      add_row(OP_PUSH_BACK, 32'sd0, 1'b0, '0);
      add_row(OP_POP_BACK, W_MIN, 1'b0, '0);
      add_row(OP_POP_FRONT, 32'sd0, 1'b0, '0);
      add_row(OP_POP_FRONT, 32'sd0, 1'b0, '0);
      add_row(OP_POP_BACK, 32'sd0, 1'b1,
              '{W_MAX, 1'b1, ST_OK, CW'(0), 1'b1, 32'sd0, 32'sd0});
      add_row(OP_POP_FRONT, 32'sd0, 1'b1, NOTHING_STORED);
      add_row(OP_PUSH_FRONT, 32'sh5555_5555, 1'b0, '0);
      add_row(OP_PUSH_BACK, 32'shAAAA_AAAA, 1'b0, '0);
      add_row(OP_SPARE_MAX, 32'sd0, 1'b0, '0);
      add_row(OP_POP_FRONT, 32'sd0, 1'b0, '0);
      add_row(OP_POP_FRONT, 32'sd0, 1'b0, '0);
      add_row(OP_PUSH_BACK, 32'sd1, 1'b0, '0);
      add_row(OP_POP_FRONT, 32'sd0, 1'b0, '0);
      add_row(OP_PUSH_FRONT, -32'sd2, 1'b0, '0);
      add_row(OP_SPARE_MIN, 32'sd0, 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < dir_n; i++)
         send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp);

      // random walk near empty
      repeat (250) send_random(40, 40);
      // fill to full, then hammer the full boundary
      while (fill_count < DEPTH) send_random(96, 2);
      repeat (60) send_random(65, 25);
      drain_outcomes();
      // work back down from the full boundary
      repeat (230) send_random(35, 55);
      start = 1'b0;

      while (exp_wr != exp_rd) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && exp_wr == exp_rd) begin
         $display("double_ended_queue: match");
      end else begin
         $display("double_ended_queue: mismatch");
      end
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_ctrl.sv
rtl/core/dq_datapath.sv
rtl/core/double_ended_queue.sv
tb/tb_top.sv
